// ===== src/pe_pkg.sv =====
// Shared constants, types and helpers for the polynomial evaluator.
package pe_pkg;

  localparam int TERMS       = 8;
  localparam int FRAC_BITS   = 16;
  localparam int NUM_COEF    = 8;
  localparam int DATA_W      = 32;
  localparam int CFG_INDEX_W = 4;
  localparam int COEF_IDX_W  = $clog2(NUM_COEF);
  localparam int PROD_W      = 2 * DATA_W;
  localparam int SHR_W       = PROD_W - FRAC_BITS;
  localparam int SUM_W       = SHR_W + 1;
  // Edges from an accepted start to the edge that takes its result.
  localparam int PIPE_LAT    = 2 * (TERMS - 1) + 2;

  typedef struct packed {
    logic                     valid;
    logic signed [DATA_W-1:0] x;
    logic signed [DATA_W-1:0] acc;
    logic signed [DATA_W-1:0] pw;
    logic                     sat;
  } stage_t;

  typedef struct packed {
    logic                     sat;
    logic signed [DATA_W-1:0] value;
  } clamp_t;

  // Saturates a wide signed value to the signed data range.
  function automatic clamp_t clamp(input logic signed [SUM_W-1:0] v);
    clamp_t r;
    r.sat   = 1'b0;
    r.value = v[DATA_W-1:0];
    if (!((&v[SUM_W-1:DATA_W-1]) || !(|v[SUM_W-1:DATA_W-1]))) begin
      r.sat = 1'b1;
      if (v[SUM_W-1]) begin
        r.value = {1'b1, {(DATA_W-1){1'b0}}};
      end else begin
        r.value = {1'b0, {(DATA_W-1){1'b1}}};
      end
    end
    return r;
  endfunction

endpackage

// ===== src/pe_term.sv =====
// One term of the power series: multiply stage, then shift, add and clamp stage.
module pe_term import pe_pkg::*; (
  input  logic                     clk,
  input  logic                     rst,
  input  logic signed [DATA_W-1:0] coef,
  input  logic                     use_power,
  input  stage_t                   in_stage,
  output stage_t                   out_stage
);

  logic signed [DATA_W-1:0] pw_in;
  logic signed [DATA_W-1:0] x_in;
  logic signed [PROD_W-1:0] tprod_next;
  logic signed [PROD_W-1:0] pprod_next;

  logic                     a_valid;
  logic signed [DATA_W-1:0] a_x;
  logic signed [DATA_W-1:0] a_acc;
  logic                     a_sat;
  logic signed [PROD_W-1:0] a_tprod;
  logic signed [PROD_W-1:0] a_pprod;

  logic signed [SHR_W-1:0]  tshr;
  logic signed [SHR_W-1:0]  pshr;
  logic signed [SUM_W-1:0]  sum;
  clamp_t                   acc_c;
  clamp_t                   pw_c;

  assign pw_in      = in_stage.pw;
  assign x_in       = in_stage.x;
  assign tprod_next = PROD_W'(coef) * PROD_W'(pw_in);
  assign pprod_next = PROD_W'(pw_in) * PROD_W'(x_in);

  always_ff @(posedge clk) begin
    if (rst) begin
      a_valid <= 1'b0;
    end else begin
      a_valid <= in_stage.valid;
    end
    a_x     <= x_in;
    a_acc   <= in_stage.acc;
    a_sat   <= in_stage.sat;
    a_tprod <= tprod_next;
    a_pprod <= pprod_next;
  end

  // Dropping the low fraction bits of a two's complement product is a floor shift.
  assign tshr  = $signed(a_tprod[PROD_W-1:FRAC_BITS]);
  assign pshr  = $signed(a_pprod[PROD_W-1:FRAC_BITS]);
  assign sum   = SUM_W'(a_acc) + SUM_W'(tshr);
  assign acc_c = clamp(sum);
  assign pw_c  = clamp(SUM_W'(pshr));

  always_ff @(posedge clk) begin
    if (rst) begin
      out_stage.valid <= 1'b0;
    end else begin
      out_stage.valid <= a_valid;
    end
    out_stage.x   <= a_x;
    out_stage.acc <= acc_c.value;
    out_stage.pw  <= pw_c.value;
    out_stage.sat <= a_sat | acc_c.sat | (use_power & pw_c.sat);
  end

endmodule

// ===== src/polynomial_evaluate.sv =====
// Top level of the pipelined fixed-point polynomial evaluator.
// A new x word may be started in every cycle; busy is high only during reset.
// Each word gives exactly one result, strobed by done for one cycle. The word
// passes one input register, two stages per term for terms one through seven
// (two 32x32 multipliers, then shift, add and clamp), and one output register.
// The receiver cannot hold a result off, so it must take it in that cycle.
// Coefficients are to be written through the cfg port only while no word is
// in flight; the block itself does not enforce this. Indexes above seven are
// ignored.
module polynomial_evaluate import pe_pkg::*; (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          start,
  output logic                          busy,
  input  logic signed [DATA_W-1:0]      x_value,
  output logic                          done,
  output logic signed [DATA_W-1:0]      poly_value,
  output logic                          saturated,
  input  logic                          cfg_valid,
  output logic                          cfg_ready,
  input  logic        [CFG_INDEX_W-1:0] cfg_index,
  input  logic        [DATA_W-1:0]      cfg_data
);

  logic signed [DATA_W-1:0] coef [0:NUM_COEF-1];
  stage_t                   st0;
  stage_t                   st [0:TERMS-1];

  assign busy      = rst;
  assign cfg_ready = ~rst;

  always_ff @(posedge clk) begin
    if (rst) begin
      for (int i = 0; i < NUM_COEF; i++) begin
        coef[i] <= '0;
      end
    end else if (cfg_valid && cfg_ready && (cfg_index < CFG_INDEX_W'(NUM_COEF))) begin
      coef[cfg_index[COEF_IDX_W-1:0]] <= $signed(cfg_data);
    end
  end

  // The accumulator starts at the constant term and the running power at x.
  always_ff @(posedge clk) begin
    if (rst) begin
      st0.valid <= 1'b0;
    end else begin
      st0.valid <= start & ~busy;
    end
    st0.x   <= x_value;
    st0.acc <= coef[0];
    st0.pw  <= x_value;
    st0.sat <= 1'b0;
  end

  assign st[0] = st0;

  for (genvar k = 1; k < TERMS; k++) begin : g_term
    pe_term u_term (
      .clk       (clk),
      .rst       (rst),
      .coef      (coef[k]),
      .use_power (1'((k + 1) < TERMS)),
      .in_stage  (st[k-1]),
      .out_stage (st[k])
    );
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      done <= 1'b0;
    end else begin
      done <= st[TERMS-1].valid;
    end
    poly_value <= st[TERMS-1].acc;
    saturated  <= st[TERMS-1].sat;
  end

endmodule

// ===== src/pe_checker.sv =====
// Port-level checks for the polynomial evaluator, bound to the top level.
module pe_checker import pe_pkg::*; (
  input logic                     clk,
  input logic                     rst,
  input logic                     start,
  input logic                     busy,
  input logic                     done,
  input logic                     saturated,
  input logic                     cfg_ready
);

  // Every accepted word comes out after the fixed pipeline latency.
  a_start_to_done: assert property (@(posedge clk) disable iff (rst)
    (start && !busy) |-> ##PIPE_LAT done)
    else $error("accepted word did not complete on time");

  // No result appears without a matching accepted word.
  a_done_has_start: assert property (@(posedge clk) disable iff (rst)
    done |-> $past(start && !busy && !rst, PIPE_LAT))
    else $error("done strobe without an accepted word");

  // The block never refuses work outside reset.
  a_ready_out_of_reset: assert property (@(posedge clk)
    !rst |-> (!busy && cfg_ready))
    else $error("busy or cfg stall outside reset");

  // The flag shown with a result is always a known value. Between results it
  // follows whatever the idle pipeline slots compute and means nothing.
  a_sat_known_with_done: assert property (@(posedge clk) disable iff (rst)
    done |-> !$isunknown(saturated))
    else $error("result carries an unknown saturation flag");

endmodule

bind polynomial_evaluate pe_checker u_pe_checker (
  .clk       (clk),
  .rst       (rst),
  .start     (start),
  .busy      (busy),
  .done      (done),
  .saturated (saturated),
  .cfg_ready (cfg_ready)
);

// ===== dv/poly_result_checker.sv =====
// Checker for the polynomial evaluator: predicts each result and compares it with the block.
`timescale 1ns / 100ps
module poly_result_checker import pe_pkg::*; (
  input  logic                         clk,
  input  logic                         rst,
  input  logic                         start,
  input  logic                         busy,
  input  logic signed [DATA_W-1:0]     x_value,
  input  logic                         done,
  input  logic signed [DATA_W-1:0]     poly_value,
  input  logic                         saturated,
  input  logic                         cfg_valid,
  input  logic                         cfg_ready,
  input  logic        [CFG_INDEX_W-1:0] cfg_index,
  input  logic        [DATA_W-1:0]     cfg_data,
  output int                           mismatches,
  output int                           in_flight
);

  typedef struct packed {
    logic signed [DATA_W-1:0] value;
    logic                     sat;
  } poly_result_t;

  localparam longint S32_HI = 64'sd2147483647;
  localparam longint S32_LO = -64'sd2147483648;

  logic signed [DATA_W-1:0] coef_q [NUM_COEF];
  poly_result_t             expected_poly [$];

  initial begin
    mismatches = 0;
    in_flight  = 0;
  end

  task automatic report_mismatch(input string msg);
    $display("%0t: %s", $time, msg);
    mismatches++;
  endtask

  function automatic longint limit32(input longint v, inout logic flag);
    if (v > S32_HI) begin
      flag = 1'b1;
      return S32_HI;
    end
    if (v < S32_LO) begin
      flag = 1'b1;
      return S32_LO;
    end
    return v;
  endfunction

  // Power-series order: the term product is added at full width, only the sum is clamped.
  function automatic poly_result_t eval_poly(input logic signed [DATA_W-1:0] x);
    longint       acc;
    longint       pw;
    logic         sat;
    poly_result_t r;
    acc = longint'(coef_q[0]);
    pw  = longint'(x);
    sat = 1'b0;
    for (int k = 1; k < TERMS; k++) begin
      acc = limit32(acc + ((longint'(coef_q[k]) * pw) >>> FRAC_BITS), sat);
      // The power past the last term is never formed, so it cannot raise the flag.
      if (k + 1 < TERMS) begin
        pw = limit32((pw * longint'(x)) >>> FRAC_BITS, sat);
      end
    end
    r.value = acc[DATA_W-1:0];
    r.sat   = sat;
    return r;
  endfunction

  always @(posedge clk) begin : watch
    poly_result_t want;
    if (rst) begin
      foreach (coef_q[k]) coef_q[k] = '0;
      expected_poly.delete();
    end else begin
      if (cfg_valid && cfg_ready && cfg_index < NUM_COEF) begin
        coef_q[cfg_index[COEF_IDX_W-1:0]] = cfg_data;
      end
      // Retire before predicting, so a result can never meet the word started at its own edge.
      if (done) begin
        if (expected_poly.size() == 0) begin
          report_mismatch($sformatf("result %h with no word in flight", poly_value));
        end else begin
          want = expected_poly.pop_front();
          if (poly_value !== want.value) begin
            report_mismatch($sformatf("poly_value %h, predicted %h", poly_value, want.value));
          end
          if (saturated !== want.sat) begin
            report_mismatch($sformatf("saturated %b, predicted %b", saturated, want.sat));
          end
        end
      end
      if (start && !busy) begin
        expected_poly.push_back(eval_poly(x_value));
      end
    end
    in_flight <= expected_poly.size();
  end

endmodule

// ===== dv/testbench.sv =====
// Testbench top for the polynomial evaluator: drives x words and coefficient writes.
`timescale 1ns / 100ps
module testbench;
  import pe_pkg::*;

  typedef enum int {COEF_SMALL, COEF_FULL, COEF_MIXED, COEF_EXTREME} coef_style_t;

  localparam logic [DATA_W-1:0] Q_ONE = 32'h0001_0000;
  localparam logic [DATA_W-1:0] S_MAX = 32'h7FFF_FFFF;
  localparam logic [DATA_W-1:0] S_MIN = 32'h8000_0000;
  localparam int RAND_PHASES = 10;
  localparam int PHASE_WORDS = 163;

  logic                     clk       = 1'b0;
  logic                     rst       = 1'b1;
  logic                     start     = 1'b0;
  logic signed [DATA_W-1:0] x_value   = '0;
  logic                     cfg_valid = 1'b0;
  logic [CFG_INDEX_W-1:0]   cfg_index = '0;
  logic [DATA_W-1:0]        cfg_data  = '0;
  logic                     busy;
  logic                     done;
  logic signed [DATA_W-1:0] poly_value;
  logic                     saturated;
  logic                     cfg_ready;
  int                       mismatches;
  int                       in_flight;

  logic [DATA_W-1:0] coef_set [NUM_COEF];
  bit                gaps_on    = 1'b1;
  int                words_sent = 0;
  int                settings   = 0;

  polynomial_evaluate dut (.*);

  poly_result_checker u_check (.*);

  always begin
    #10 clk = 1'b1;
    #10 clk = 1'b0;
  end

  initial begin
    #2000000;
    $display("Timed out with %0d words still in flight", in_flight);
    $display("Mismatches found");
    $finish;
  end

  function automatic logic [DATA_W-1:0] pick_coef(input coef_style_t style);
    case (style)
      COEF_SMALL: return $urandom_range(0, 32'h1_FFFF) - 32'h1_0000;
      COEF_FULL: return $urandom;
      COEF_MIXED: return pick_coef(coef_style_t'($urandom_range(0, 3)));
      default: begin
        case ($urandom_range(0, 4))
          0: return S_MAX;
          1: return S_MIN;
          2: return '0;
          3: return Q_ONE;
          default: return -Q_ONE;
        endcase
      end
    endcase
  endfunction

  // Mostly points near the origin, where the higher powers stay in range.
  function automatic logic [DATA_W-1:0] pick_x();
    int r;
    r = $urandom_range(0, 99);
    if (r < 10) return pick_coef(COEF_EXTREME);
    if (r < 45) return $urandom_range(0, 32'h3_FFFF) - 32'h2_0000;
    if (r < 70) return $urandom_range(0, 32'h1F_FFFF) - 32'h10_0000;
    return $urandom;
  endfunction

  task automatic send_x(input logic [DATA_W-1:0] x);
    if (gaps_on) begin
      while ($urandom_range(0, 99) < 10) begin
        start <= 1'b0;
        @(posedge clk);
      end
    end
    start   <= 1'b1;
    x_value <= x;
    do @(posedge clk); while (busy);
    words_sent++;
  endtask

  task automatic drain_words();
    start <= 1'b0;
    do @(posedge clk); while (in_flight != 0);
  endtask

  task automatic write_reg(input logic [CFG_INDEX_W-1:0] idx, input logic [DATA_W-1:0] data);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= data;
    do @(posedge clk); while (!cfg_ready);
  endtask

  task automatic load_coefs();
    drain_words();
    for (int k = 0; k < NUM_COEF; k++) begin
      write_reg(CFG_INDEX_W'(k), coef_set[k]);
    end
    // A write past the last coefficient must leave every coefficient alone.
    write_reg(CFG_INDEX_W'($urandom_range(NUM_COEF, 2 ** CFG_INDEX_W - 1)), $urandom);
    cfg_valid <= 1'b0;
    settings++;
  endtask

  initial begin
    coef_style_t style;
    repeat (6) @(posedge clk);
    rst <= 1'b0;

    // Every coefficient is zero out of reset.
    send_x(S_MAX);
    send_x(S_MIN);

    // Unit coefficients: p(x) is the plain sum of the powers of x.
    foreach (coef_set[k]) coef_set[k] = Q_ONE;
    load_coefs();
    send_x('0);
    send_x(Q_ONE);
    send_x(-Q_ONE);
    send_x(32'h1);
    send_x('1);
    send_x(32'h8000);

    foreach (coef_set[k]) coef_set[k] = S_MAX;
    load_coefs();
    send_x(S_MAX);
    send_x(S_MIN);
    send_x(Q_ONE);

    foreach (coef_set[k]) coef_set[k] = S_MIN;
    load_coefs();
    send_x(S_MIN);
    send_x(S_MAX);
    send_x('1);

    // Only the constant term is set, yet the powers of a huge x still clamp.
    foreach (coef_set[k]) coef_set[k] = '0;
    coef_set[0] = S_MIN;
    load_coefs();
    send_x(S_MAX);
    send_x(32'h0100_0000);

    // A term twice the signed range is added whole; only the sum may clamp.
    coef_set[1] = S_MAX;
    load_coefs();
    send_x(32'h2_0000);
    send_x(-32'h2_0000);

    for (int p = 0; p < RAND_PHASES; p++) begin
      style = coef_style_t'(p % 4);
      foreach (coef_set[k]) coef_set[k] = pick_coef(style);
      load_coefs();
      gaps_on = (p != 2);
      for (int n = 0; n < PHASE_WORDS; n++) begin
        if (p == 5 && n == PHASE_WORDS / 2) begin
          drain_words();
        end
        send_x(pick_x());
      end
    end

    drain_words();
    repeat (PIPE_LAT + 4) @(posedge clk);
    $display("Drove %0d x words under %0d coefficient settings, from zeros to full scale,",
             words_sent, settings);
    $display("with random gaps, one back-to-back stretch and a drain in mid-stream.");
    if (mismatches == 0) begin
      $display("No mismatches found");
    end else begin
      $display("Mismatches found");
    end
    $finish;
  end

endmodule
